// File: rtl/ncg_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package ncg_pkg;

    // Defaults for the top-level parameters
    localparam int MAX_K_DEF      = 16;
    localparam int VALUE_BITS_DEF = 8;

    // Fixed field widths
    localparam int N_W        = 8;
    localparam int K_W        = 5;
    localparam int POS_W      = 4;
    localparam int OVAL_W     = 8;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 8;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_RANGE_N = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SIZE_K  = 2'd1;

    // Reset values of the registers
    localparam logic [N_W-1:0] RANGE_N_RST = 8'd8;
    localparam logic [K_W-1:0] SIZE_K_RST  = 5'd2;

    // Operation codes
    localparam logic OP_LOAD    = 1'b0;
    localparam logic OP_ADVANCE = 1'b1;

    typedef enum logic [2:0] {
        S_IDLE,
        S_WALK_RD,
        S_WALK_UPD,
        S_CHK_RD,
        S_CHK,
        S_FILL,
        S_EMIT_RD,
        S_EMIT
    } state_t;

    // Controller -> datapath
    typedef struct packed {
        logic load_wr;      // write load item into store
        logic walk_wr;      // write incremented element, capture it as refill seed
        logic fill_wr;      // write next consecutive value
        logic rd_en;        // issue store read
        logic rd_zero;      // read element 0 instead of idx
        logic idx_to_last;  // idx <= k-1
        logic idx_clr;      // idx <= 0
        logic idx_inc;
        logic idx_dec;
        logic ok_set;
        logic ok_clr;
        logic ok_chk_ld;    // ok <= element 0 <= n-k
        logic out_load;     // load output register
    } cmd_t;

    // Datapath -> controller
    typedef struct packed {
        logic over;         // incremented element reached its limit
        logic ok_chk;       // read element is at most n-k
        logic idx_zero;
        logic idx_last;
        logic out_free;     // output register can take a transaction
    } sts_t;

endpackage

`default_nettype wire

// File: rtl/ncg_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface ncg_item_if;
    logic                       valid;
    logic                       ready;
    logic                       operation;
    logic [ncg_pkg::POS_W-1:0]  position;
    logic [ncg_pkg::N_W-1:0]    value;

    modport source (output valid, output operation, output position, output value,
                    input ready);
    modport sink   (input valid, input operation, input position, input value,
                    output ready);
endinterface

interface ncg_result_if;
    logic                       valid;
    logic                       ready;
    logic [ncg_pkg::POS_W-1:0]  out_position;
    logic [ncg_pkg::OVAL_W-1:0] out_value;
    logic                       has_next;
    logic                       last;

    modport source (output valid, output out_position, output out_value,
                    output has_next, output last, input ready);
    modport sink   (input valid, input out_position, input out_value,
                    input has_next, input last, output ready);
endinterface

interface ncg_cfg_if;
    logic                           valid;
    logic                           ready;
    logic [ncg_pkg::CFG_IDX_W-1:0]  index;
    logic [ncg_pkg::CFG_DATA_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

// File: rtl/ncg_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none

module ncg_ctrl (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          item_valid,
    input  wire logic          item_op,
    output logic               item_ready,
    input  wire ncg_pkg::sts_t sts,
    output ncg_pkg::cmd_t      cmd
);
    import ncg_pkg::*;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (item_valid && (item_op == OP_ADVANCE))
                begin
                    state_next = S_WALK_RD;
                end
            end
            S_WALK_RD:
            begin
                state_next = S_WALK_UPD;
            end
            S_WALK_UPD:
            begin
                if (sts.over)
                begin
                    state_next = sts.idx_zero ? S_EMIT_RD : S_WALK_RD;
                end
                else if (sts.idx_zero)
                begin
                    state_next = sts.idx_last ? S_EMIT_RD : S_FILL;
                end
                else
                begin
                    state_next = S_CHK_RD;
                end
            end
            S_CHK_RD:
            begin
                state_next = S_CHK;
            end
            S_CHK:
            begin
                state_next = (sts.ok_chk && !sts.idx_last) ? S_FILL : S_EMIT_RD;
            end
            S_FILL:
            begin
                state_next = sts.idx_last ? S_EMIT_RD : S_FILL;
            end
            S_EMIT_RD:
            begin
                state_next = S_EMIT;
            end
            S_EMIT:
            begin
                if (sts.out_free)
                begin
                    state_next = sts.idx_last ? S_IDLE : S_EMIT_RD;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Outputs
    always_comb
    begin
        cmd        = '0;
        item_ready = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                item_ready      = 1'b1;
                cmd.load_wr     = item_valid && (item_op == OP_LOAD);
                cmd.idx_to_last = item_valid && (item_op == OP_ADVANCE);
            end
            S_WALK_RD:
            begin
                cmd.rd_en = 1'b1;
            end
            S_WALK_UPD:
            begin
                cmd.walk_wr = 1'b1;
                if (sts.over)
                begin
                    if (sts.idx_zero)
                    begin
                        cmd.ok_clr  = 1'b1;
                        cmd.idx_clr = 1'b1;
                    end
                    else
                    begin
                        cmd.idx_dec = 1'b1;
                    end
                end
                else if (sts.idx_zero)
                begin
                    cmd.ok_set  = 1'b1;
                    cmd.idx_clr = sts.idx_last;
                    cmd.idx_inc = !sts.idx_last;
                end
            end
            S_CHK_RD:
            begin
                cmd.rd_en   = 1'b1;
                cmd.rd_zero = 1'b1;
            end
            S_CHK:
            begin
                cmd.ok_chk_ld = 1'b1;
                if (sts.ok_chk && !sts.idx_last)
                begin
                    cmd.idx_inc = 1'b1;
                end
                else
                begin
                    cmd.idx_clr = 1'b1;
                end
            end
            S_FILL:
            begin
                cmd.fill_wr = 1'b1;
                cmd.idx_clr = sts.idx_last;
                cmd.idx_inc = !sts.idx_last;
            end
            S_EMIT_RD:
            begin
                cmd.rd_en = 1'b1;
            end
            S_EMIT:
            begin
                if (sts.out_free)
                begin
                    cmd.out_load = 1'b1;
                    cmd.idx_inc  = !sts.idx_last;
                end
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

endmodule

`default_nettype wire

// File: rtl/ncg_dpath.sv
`timescale 1ns / 1ps
`default_nettype none

module ncg_dpath #(
    parameter int MAX_K      = ncg_pkg::MAX_K_DEF,
    parameter int VALUE_BITS = ncg_pkg::VALUE_BITS_DEF
) (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire ncg_pkg::cmd_t                cmd,
    output ncg_pkg::sts_t                     sts,
    // load item payload
    input  wire logic [ncg_pkg::POS_W-1:0]    position,
    input  wire logic [ncg_pkg::N_W-1:0]      value,
    // register writes
    input  wire logic                         cfg_valid,
    input  wire logic [ncg_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [ncg_pkg::CFG_DATA_W-1:0] cfg_data,
    output logic                              cfg_ready,
    // result register
    input  wire logic                         res_ready,
    output logic                              res_valid,
    output logic [ncg_pkg::POS_W-1:0]         res_position,
    output logic [ncg_pkg::OVAL_W-1:0]        res_value,
    output logic                              res_has_next,
    output logic                              res_last
);
    import ncg_pkg::*;

    localparam int AW = (MAX_K > 1) ? $clog2(MAX_K) : 1;
    localparam int KW = $clog2(MAX_K + 1);
    // signed compare width: holds value+1, n, and n-k+1+i down to 1-MAX_K
    localparam int SW = ((VALUE_BITS > N_W) ? VALUE_BITS : N_W) + 2;

    // registers
    logic [N_W-1:0] range_n_reg;
    logic [K_W-1:0] size_k_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            range_n_reg <= RANGE_N_RST;
            size_k_reg  <= SIZE_K_RST;
        end
        else if (cfg_valid)
        begin
            if (cfg_index == CFG_RANGE_N)
            begin
                range_n_reg <= N_W'(cfg_data);
            end
            else if (cfg_index == CFG_SIZE_K)
            begin
                size_k_reg <= K_W'(cfg_data);
            end
        end
    end

    // effective k, clamped to 1..MAX_K
    logic [KW-1:0] k_eff;
    logic [AW-1:0] k_last;

    always_comb
    begin
        if (size_k_reg == '0)
        begin
            k_eff = KW'(1);
        end
        else if (int'(size_k_reg) > MAX_K)
        begin
            k_eff = KW'(MAX_K);
        end
        else
        begin
            k_eff = KW'(size_k_reg);
        end
    end

    assign k_last = AW'(k_eff - KW'(1));

    // element index
    logic [AW-1:0] idx_reg;
    logic [AW-1:0] idx_next;

    always_comb
    begin
        idx_next = idx_reg;
        if (cmd.idx_to_last)
        begin
            idx_next = k_last;
        end
        else if (cmd.idx_clr)
        begin
            idx_next = '0;
        end
        else if (cmd.idx_inc)
        begin
            idx_next = idx_reg + AW'(1);
        end
        else if (cmd.idx_dec)
        begin
            idx_next = idx_reg - AW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg <= '0;
        end
        else
        begin
            idx_reg <= idx_next;
        end
    end

    // combination store; entries never written read as zero
    logic [VALUE_BITS-1:0] mem [MAX_K];
    logic [MAX_K-1:0]      mem_vld_reg;
    logic [VALUE_BITS-1:0] rd_data_reg;
    logic [VALUE_BITS-1:0] fill_reg;

    logic                  wr_en;
    logic [AW-1:0]         wr_addr;
    logic [VALUE_BITS-1:0] wr_data;
    logic [AW-1:0]         rd_addr;
    logic                  load_in_range;

    logic signed [SW-1:0]  elem_s;
    logic signed [SW-1:0]  incr_s;
    logic signed [SW-1:0]  limit_s;
    logic signed [SW-1:0]  first_max_s;   // n-k
    logic [VALUE_BITS-1:0] fill_val;

    assign elem_s      = $signed(SW'(rd_data_reg));
    assign incr_s      = elem_s + SW'(1);
    assign limit_s     = $signed(SW'(range_n_reg)) + $signed(SW'(idx_reg)) + SW'(1)
                         - $signed(SW'(k_eff));
    assign first_max_s = $signed(SW'(range_n_reg)) - $signed(SW'(k_eff));
    assign fill_val    = fill_reg + VALUE_BITS'(1);

    assign load_in_range = int'(position) < MAX_K;

    always_comb
    begin
        wr_en   = 1'b0;
        wr_addr = idx_reg;
        wr_data = fill_val;
        if (cmd.load_wr)
        begin
            wr_en   = load_in_range;
            wr_addr = AW'(position);
            wr_data = VALUE_BITS'(value);
        end
        else if (cmd.walk_wr)
        begin
            wr_en   = 1'b1;
            wr_data = VALUE_BITS'(incr_s);
        end
        else if (cmd.fill_wr)
        begin
            wr_en = 1'b1;
        end
    end

    assign rd_addr = cmd.rd_zero ? '0 : idx_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (cmd.rd_en)
        begin
            rd_data_reg <= mem_vld_reg[rd_addr] ? mem[rd_addr] : '0;
        end
        if (cmd.walk_wr)
        begin
            fill_reg <= VALUE_BITS'(incr_s);
        end
        else if (cmd.fill_wr)
        begin
            fill_reg <= fill_val;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mem_vld_reg <= '0;
        end
        else if (wr_en)
        begin
            mem_vld_reg[wr_addr] <= 1'b1;
        end
    end

    // has-next flag
    logic ok_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ok_reg <= 1'b0;
        end
        else if (cmd.ok_set)
        begin
            ok_reg <= 1'b1;
        end
        else if (cmd.ok_clr)
        begin
            ok_reg <= 1'b0;
        end
        else if (cmd.ok_chk_ld)
        begin
            ok_reg <= sts.ok_chk;
        end
    end

    // result register
    logic res_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_valid_reg <= 1'b0;
        end
        else if (cmd.out_load)
        begin
            res_valid_reg <= 1'b1;
        end
        else if (res_ready)
        begin
            res_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            res_position <= POS_W'(idx_reg);
            res_value    <= OVAL_W'(rd_data_reg);
            res_has_next <= ok_reg;
            res_last     <= (idx_reg == k_last);
        end
    end

    assign res_valid = res_valid_reg;

    // status
    always_comb
    begin
        sts.over     = incr_s >= limit_s;
        sts.ok_chk   = !(elem_s > first_max_s);
        sts.idx_zero = (idx_reg == '0);
        sts.idx_last = (idx_reg == k_last);
        sts.out_free = !res_valid_reg || res_ready;
    end

endmodule

`default_nettype wire

// File: rtl/next_combination_generator.sv
// Load transaction: written to the store at the edge that accepts it if its position is below MAX_K, no result.
// Advance transaction: w elements are walked back, each read and then written; element 0
// is read again when the walk stopped above it; f elements are refilled; all k elements
// are read and emitted. The store has a registered read; result stalls hold the emit.
// One transaction at a time; the next is taken in the cycle after the last result loads.
// Reset (rst_n, async, active low): range_n = 8, size_k = 2, store reads as all zero.
`timescale 1ns / 1ps
`default_nettype none

module next_combination_generator #(
    parameter int MAX_K      = ncg_pkg::MAX_K_DEF,
    parameter int VALUE_BITS = ncg_pkg::VALUE_BITS_DEF
) (
    input  wire logic   clk,
    input  wire logic   rst_n,
    ncg_item_if.sink    item,
    ncg_result_if.source result,
    ncg_cfg_if.sink     cfg
);
    import ncg_pkg::*;

    // The controller steps through walk, check, refill and emit phases;
    // the datapath holds the store, the index counter, the registers and
    // the result register.
    //
    // Walk: from element k-1 down, read, increment, write back; stop at
    // the first element that stays below its limit n-k+1+i, or at element 0.
    // Check: when the walk stopped above element 0, element 0 is read
    // once more to decide whether a next combination exists.
    // Refill: when a next combination exists, elements after the stop point get consecutive values.
    // Emit: all k elements are read and handed out, one transaction each.

    cmd_t cmd;
    sts_t sts;

    ncg_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item.valid),
        .item_op    (item.operation),
        .item_ready (item.ready),
        .sts        (sts),
        .cmd        (cmd)
    );

    ncg_dpath #(
        .MAX_K      (MAX_K),
        .VALUE_BITS (VALUE_BITS)
    ) u_dpath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .sts          (sts),
        .position     (item.position),
        .value        (item.value),
        .cfg_valid    (cfg.valid),
        .cfg_index    (cfg.index),
        .cfg_data     (cfg.data),
        .cfg_ready    (cfg.ready),
        .res_ready    (result.ready),
        .res_valid    (result.valid),
        .res_position (result.out_position),
        .res_value    (result.out_value),
        .res_has_next (result.has_next),
        .res_last     (result.last)
    );

endmodule

`default_nettype wire

// File: tb/sv/next_combination_generator_test.sv
`timescale 1ns / 1ps

module next_combination_generator_test;
    import ncg_pkg::*;

    // Config indexes that map to no register; writes there must leave the block alone.
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_2 = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_3 = 2'd3;

    localparam int STORE_DEPTH  = MAX_K_DEF;
    localparam int SETTLE_CYC   = 100;     // idle wait before the final check
    localparam int RAND_PER_SET = 22;      // at least this many input transactions per config setting

    // One emitted element of a combination, as seen on the result channel.
    typedef struct packed {
        logic [POS_W-1:0]  position;
        logic [OVAL_W-1:0] value;
        logic              has_next;
        logic              last;
    } element_t;

    // Result-side stall patterns.
    typedef enum int {
        RX_OPEN,
        RX_COIN,
        RX_SPARSE,
        RX_MOSTLY
    } rx_mode_t;

    // Tracks the combination store and the elements the next advances must emit.
    class combo_tracker;
        logic [VALUE_BITS_DEF-1:0] store [STORE_DEPTH];
        logic [N_W-1:0]            range_n;
        logic [K_W-1:0]            size_k;
        element_t                  pending [$];
        int                        errors;
        int                        checked;
        int                        advances;
        int                        exhausted;

        function new();
            range_n = RANGE_N_RST;
            size_k  = SIZE_K_RST;
            foreach (store[i])
                store[i] = '0;
            errors    = 0;
            checked   = 0;
            advances  = 0;
            exhausted = 0;
        endfunction

        // k as the block uses it: 0 acts as 1, anything above the store depth is clamped
        function int eff_size();
            int kk;
            kk = size_k;
            if (kk == 0)
                kk = 1;
            if (kk > STORE_DEPTH)
                kk = STORE_DEPTH;
            return kk;
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            if (idx == CFG_RANGE_N)
                range_n = data;
            else if (idx == CFG_SIZE_K)
                size_k = data[K_W-1:0];
        endfunction

        function void report(string msg);
            errors++;
            if (errors <= 10)
                $display("MISMATCH @%0t: %s", $time, msg);
        endfunction

        // Accepted input transaction: a load writes the store, an advance
        // steps to the next combination and queues all k elements.
        function void note_item(logic op, logic [POS_W-1:0] pos, logic [N_W-1:0] val);
            int       work [STORE_DEPTH];
            int       kk;
            int       nn;
            int       i;
            bit       ok;
            element_t e;
            if (op == OP_LOAD) begin
                store[pos] = val;
                return;
            end
            advances++;
            kk = eff_size();
            nn = range_n;
            for (int j = 0; j < kk; j++)
                work[j] = store[j];
            // walk left while the incremented element reaches its limit n-k+1+i
            i = kk - 1;
            work[i]++;
            while (i >= 0 && work[i] >= nn - kk + 1 + i) begin
                i--;
                if (i >= 0)
                    work[i]++;
            end
            ok = !(work[0] > nn - kk);
            if (ok) begin
                for (int j = i + 1; j < kk; j++)
                    work[j] = work[j-1] + 1;
            end
            else begin
                exhausted++;
            end
            for (int j = 0; j < kk; j++)
                store[j] = 8'(work[j]);
            for (int j = 0; j < kk; j++) begin
                e.position = 4'(j);
                e.value    = store[j];
                e.has_next = ok;
                e.last     = (j == kk - 1);
                pending.push_back(e);
            end
        endfunction

        function void check_result(element_t got);
            element_t want;
            if (pending.size() == 0) begin
                report($sformatf("unexpected result pos=%0d value=%0d has_next=%0b last=%0b",
                                 got.position, got.value, got.has_next, got.last));
                return;
            end
            want = pending.pop_front();
            checked++;
            if (got.position !== want.position || got.value !== want.value ||
                got.has_next !== want.has_next || got.last !== want.last)
                report($sformatf({"expected pos=%0d value=%0d has_next=%0b last=%0b, ",
                                  "got pos=%0d value=%0d has_next=%0b last=%0b"},
                                 want.position, want.value, want.has_next, want.last,
                                 got.position, got.value, got.has_next, got.last));
        endfunction

        // Anything still queued at the end never showed up.
        function void close_out();
            element_t want;
            while (pending.size() > 0) begin
                want = pending.pop_front();
                report($sformatf("missing result pos=%0d value=%0d has_next=%0b last=%0b",
                                 want.position, want.value, want.has_next, want.last));
            end
        endfunction
    endclass

    logic clk;
    logic rst_n;

    ncg_item_if   item_ch ();
    ncg_result_if result_ch ();
    ncg_cfg_if    cfg_ch ();

    next_combination_generator dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .item   (item_ch),
        .result (result_ch),
        .cfg    (cfg_ch)
    );

    combo_tracker tracker = new();

    int items_sent  = 0;
    int cfg_writes  = 0;
    int burst_left  = 0;

    rx_mode_t rx_mode   = RX_OPEN;
    int       rx_left   = 0;
    int       rx_tick   = 0;

    always #5 clk = ~clk;

    // Receiver: ready follows one stall pattern for a random stretch, then another.
    always @(negedge clk) begin
        if (rx_left == 0) begin
            rx_mode = rx_mode_t'($urandom_range(3, 0));
            rx_left = $urandom_range(300, 20);
        end
        rx_left--;
        rx_tick++;
        case (rx_mode)
            RX_OPEN:   result_ch.ready <= 1'b1;
            RX_COIN:   result_ch.ready <= 1'($urandom_range(1, 0));
            RX_SPARSE: result_ch.ready <= (rx_tick % 4 == 0);
            default:   result_ch.ready <= ($urandom_range(7, 0) != 0);
        endcase
    end

    // Result monitor: every accepted result transaction goes to the tracker.
    always @(posedge clk) begin : result_monitor
        element_t got;
        if (rst_n && result_ch.valid && result_ch.ready) begin
            got.position = result_ch.out_position;
            got.value    = result_ch.out_value;
            got.has_next = result_ch.has_next;
            got.last     = result_ch.last;
            tracker.check_result(got);
        end
    end

    // Sender: transactions go out in bursts; between bursts valid may drop for a
    // random gap. Some bursts are long, giving stretches with no idling.
    task send_item(input logic op, input logic [POS_W-1:0] pos, input logic [N_W-1:0] val);
        int gap;
        @(negedge clk);
        if (burst_left == 0) begin
            gap = $urandom_range(6, 0);
            if (gap > 0) begin
                item_ch.valid <= 1'b0;
                repeat (gap) @(negedge clk);
            end
            burst_left = ($urandom_range(3, 0) == 0) ? $urandom_range(60, 20)
                                                     : $urandom_range(8, 1);
        end
        burst_left--;
        item_ch.valid     <= 1'b1;
        item_ch.operation <= op;
        item_ch.position  <= pos;
        item_ch.value     <= val;
        do
            @(posedge clk);
        while (!item_ch.ready);
        tracker.note_item(op, pos, val);
        items_sent++;
    endtask

    // Hold off the sender until every queued element has come back, then
    // let the block settle (a trailing load produces nothing to wait on).
    task drain_results();
        @(negedge clk);
        item_ch.valid <= 1'b0;
        burst_left = 0;
        while (tracker.pending.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
    endtask

    task set_register(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        @(negedge clk);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= data;
        do
            @(posedge clk);
        while (!cfg_ch.ready);
        tracker.write_reg(idx, data);
        cfg_writes++;
        @(negedge clk);
        cfg_ch.valid <= 1'b0;
    endtask

    // Random loads and advances on whatever the store holds.
    task send_noise();
        int kk;
        int nn;
        kk = tracker.eff_size();
        nn = tracker.range_n;
        repeat ($urandom_range(6, 1)) begin
            if ($urandom_range(2, 0) == 0)
                send_item(OP_ADVANCE, 4'($urandom), 8'($urandom));
            else if ($urandom_range(1, 0) == 0)
                send_item(OP_LOAD, 4'($urandom), 8'($urandom));
            else
                send_item(OP_LOAD, 4'($urandom_range(kk - 1, 0)),
                          8'($urandom_range(nn + kk, 0)));
        end
    endtask

    // Well-formed run when k <= n, else noise: load a valid combination, then advance a few times.
    // A quarter of the runs pin the tail at its limits so carries and
    // exhaustion show up often.
    task send_combination_run();
        int                kk;
        int                nn;
        int                tail;
        int                prev;
        int                hi;
        logic [N_W-1:0]    vals [STORE_DEPTH];
        kk = tracker.eff_size();
        nn = tracker.range_n;
        if (kk > nn) begin
            send_noise();
            return;
        end
        tail = ($urandom_range(3, 0) == 0) ? $urandom_range(kk - 1, 0) : kk;
        prev = -1;
        for (int j = 0; j < kk; j++) begin
            hi = nn - kk + j;
            vals[j] = (j >= tail) ? 8'(hi) : 8'($urandom_range(hi, prev + 1));
            prev = vals[j];
        end
        if ($urandom_range(1, 0) == 1) begin
            for (int j = 0; j < kk; j++)
                send_item(OP_LOAD, 4'(j), vals[j]);
        end
        else begin
            for (int j = kk - 1; j >= 0; j--)
                send_item(OP_LOAD, 4'(j), vals[j]);
        end
        // position/value of an advance are don't-care, so randomize them
        repeat ($urandom_range(5, 1))
            send_item(OP_ADVANCE, 4'($urandom), 8'($urandom));
    endtask

    initial begin : main
        logic [N_W-1:0]        set_n [$];
        logic [CFG_DATA_W-1:0] set_k [$];
        int                    start;
        int                    pick;
        clk               = 1'b0;
        rst_n             = 1'b0;
        item_ch.valid     = 1'b0;
        item_ch.operation = OP_LOAD;
        item_ch.position  = '0;
        item_ch.value     = '0;
        cfg_ch.valid      = 1'b0;
        cfg_ch.index      = CFG_RANGE_N;
        cfg_ch.data       = '0;
        result_ch.ready   = 1'b0;

        // extremes of n and k, k = 0, k above the store depth, k > n
        set_n = '{8'd255, 8'd1, 8'd10, 8'd20, 8'd40, 8'd3, 8'd12, 8'd6};
        set_k = '{8'd16, 8'd1, 8'd0, 8'hF3, 8'hEC, 8'd5, 8'd4, 8'd3};
        set_n.push_back(8'($urandom_range(40, 2)));
        set_k.push_back({3'($urandom), 5'($urandom_range(8, 1))});

        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Directed part at reset config (n = 8, k = 2).
        send_item(OP_LOAD, 4'd15, 8'd255);     // position beyond k, top value
        send_item(OP_LOAD, 4'd0, 8'd0);
        send_item(OP_LOAD, 4'd1, 8'd1);
        send_item(OP_ADVANCE, 4'd0, 8'd0);     // plain step of the last element
        send_item(OP_ADVANCE, 4'd15, 8'd255);
        send_item(OP_LOAD, 4'd1, 8'd7);
        send_item(OP_ADVANCE, 4'd0, 8'd0);     // carry into element 0, then refill
        send_item(OP_LOAD, 4'd0, 8'd6);
        send_item(OP_LOAD, 4'd1, 8'd7);
        send_item(OP_ADVANCE, 4'd0, 8'd0);     // last combination -> exhausted
        send_item(OP_ADVANCE, 4'd0, 8'd0);     // exhausted again, store keeps growing
        send_item(OP_LOAD, 4'd0, 8'd255);
        send_item(OP_LOAD, 4'd1, 8'd255);
        send_item(OP_ADVANCE, 4'd0, 8'd0);     // increments past 8 bits, store wraps
        send_item(OP_ADVANCE, 4'd0, 8'd0);
        send_item(OP_LOAD, 4'd10, 8'hAA);
        send_item(OP_LOAD, 4'd5, 8'h55);
        send_item(OP_ADVANCE, 4'd0, 8'd0);
        drain_results();

        // One random phase per config setting; config only changes when idle.
        foreach (set_n[s]) begin
            set_register(CFG_RANGE_N, set_n[s]);
            set_register(CFG_SIZE_K, set_k[s]);
            if (s == 2) begin
                set_register(CFG_SPARE_2, 8'($urandom));
                set_register(CFG_SPARE_3, 8'($urandom));
            end
            start = items_sent;
            while (items_sent - start < RAND_PER_SET) begin
                pick = $urandom_range(9, 0);
                if (pick < 2)
                    send_noise();
                else if (pick == 2)
                    drain_results();           // sender holds until all results are back
                else
                    send_combination_run();
            end
            drain_results();
        end

        repeat (SETTLE_CYC) @(posedge clk);
        tracker.close_out();

        $display("covered %0d input transactions (%0d advances, %0d exhausted), %0d config writes",
                 items_sent, tracker.advances, tracker.exhausted, cfg_writes);
        $display("checked %0d result transactions over %0d config settings, %0d failures",
                 tracker.checked, set_n.size() + 1, tracker.errors);
        if (tracker.errors == 0)
            $display("next_combination_generator_test: clean");
        else
            $display("next_combination_generator_test: errors");
        $finish;
    end

    // Hard stop: far above the slowest legal run.
    initial begin : watchdog
        #5_000_000;
        $display("timeout at %0t", $time);
        $display("next_combination_generator_test: errors");
        $finish;
    end

endmodule
